### rtl/core/ksp_pkg.sv
`default_nettype none

package ksp_pkg;

	localparam int VALUE_W = 32;
	localparam int PAIR_W  = 16;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	// word index of the target register (paddr[2])
	localparam logic REG_TARGET = 1'b0;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last_of_set;
	} item_t;

	typedef struct packed {
		logic              matched;
		logic [PAIR_W-1:0] pair_count;
		logic              table_full;
		logic              set_done;
	} result_t;

	// what the scan found so far
	typedef struct packed {
		logic hit;
		logic same;
		logic spare;
	} scan_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

endpackage

`default_nettype wire

### rtl/core/k_sum_pair_counter_core.sv
// channel   | handshake                   | payload
// ----------+-----------------------------+--------------------------------
// item      | item_valid / item_ready     | item   (value, last_of_set)
// result    | result_valid / result_ready | result (matched, pair_count, ...)
// config    | psel penable pwrite pready  | paddr, pwdata, prdata
//
// The result is registered after the item is accepted and its scan is done. The scan reads
// fill table entries, fill being the number in use (at most TABLE_ENTRIES): one entry of
// the table memory is read per cycle through the single read port, the last word is compared
// in the next cycle, then the sequencer enters commit, which commits the update.
// item_ready is low while an item is in the scan and rises the cycle after commit, so
// a new item is taken only once the last one is committed; commit waits for the result
// register to be free. Reset empties the table (fill count) and clears the count.
`default_nettype none

module k_sum_pair_counter_core #(
	parameter int TABLE_ENTRIES = 64,
	parameter int COUNT_WIDTH   = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_ready,
	input  wire ksp_pkg::item_t              item,
	output logic                             result_valid,
	input  wire logic                        result_ready,
	output ksp_pkg::result_t                 result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ksp_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [ksp_pkg::DATA_W-1:0]  pwdata,
	output logic      [ksp_pkg::DATA_W-1:0]  prdata,
	output logic                             pready
);

	import ksp_pkg::*;

	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
	localparam int WORD_W = VALUE_W + COUNT_WIDTH;
	localparam logic [FILL_W-1:0]      FILL_MAX = FILL_W'(TABLE_ENTRIES);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

	state_t state_q, next_state;

	logic [VALUE_W-1:0]     target_q;
	logic [VALUE_W-1:0]     value_q;
	logic [VALUE_W:0]       diff_q;
	logic                   last_q;
	logic [FILL_W-1:0]      fill_q;
	logic [FILL_W-1:0]      scan_idx_q;
	logic [PAIR_W-1:0]      pairs_q;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic                   result_valid_q;
	result_t                result_q;

	logic                   accept, rd_en, commit;
	logic [WORD_W-1:0]      rd_word;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_idx;
	logic [COUNT_WIDTH-1:0] wr_cnt;
	logic [VALUE_W-1:0]     wr_key;
	logic                   grow;
	logic                   full;
	logic [PAIR_W-1:0]      pairs_nxt;

	scan_t                  found;
	logic [IDX_W-1:0]       hit_idx, same_idx, spare_idx;
	logic [COUNT_WIDTH-1:0] hit_cnt, same_cnt;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TARGET) ? target_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_TARGET)) begin
			target_q <= pwdata;
		end
	end

	// sequencer
	always_comb begin
		next_state = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) next_state = ST_SCAN;
			end
			ST_SCAN: begin
				if (!rd_en && !rd_vld_s1) next_state = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (commit) next_state = ST_IDLE;
			end
			default: next_state = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = (state_q == ST_IDLE);
		rd_en      = (state_q == ST_SCAN) && (scan_idx_q < fill_q);
		commit     = (state_q == ST_COMMIT) && (!result_valid_q || result_ready);
	end

	assign accept = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			state_q   <= next_state;
			rd_vld_s1 <= rd_en;
			if (accept) begin
				scan_idx_q <= '0;
			end else if (rd_en) begin
				scan_idx_q <= scan_idx_q + FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= item.value;
			last_q  <= item.last_of_set;
			diff_q  <= {target_q[VALUE_W-1], target_q} - {item.value[VALUE_W-1], item.value};
		end
		if (rd_en) begin
			rd_idx_s1 <= scan_idx_q[IDX_W-1:0];
		end
	end

	ksp_table #(
		.DEPTH  (TABLE_ENTRIES),
		.IDX_W  (IDX_W),
		.WORD_W (WORD_W)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_idx  (scan_idx_q[IDX_W-1:0]),
		.rd_word (rd_word),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_word ({wr_key, wr_cnt})
	);

	ksp_scan #(
		.IDX_W   (IDX_W),
		.COUNT_W (COUNT_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.ent_vld   (rd_vld_s1),
		.ent_idx   (rd_idx_s1),
		.ent_key   (rd_word[WORD_W-1:COUNT_WIDTH]),
		.ent_cnt   (rd_word[COUNT_WIDTH-1:0]),
		.value     (value_q),
		.diff      (diff_q),
		.found     (found),
		.hit_idx   (hit_idx),
		.hit_cnt   (hit_cnt),
		.same_idx  (same_idx),
		.same_cnt  (same_cnt),
		.spare_idx (spare_idx)
	);

	// update decision; a spent entry below the fill mark beats growing the table
	always_comb begin
		wr_en  = 1'b0;
		wr_idx = spare_idx;
		wr_key = value_q;
		wr_cnt = CNT_ONE;
		grow   = 1'b0;
		full   = 1'b0;
		if (found.hit) begin
			wr_en  = commit;
			wr_idx = hit_idx;
			wr_key = diff_q[VALUE_W-1:0];
			wr_cnt = hit_cnt - CNT_ONE;
		end else if (found.same) begin
			wr_idx = same_idx;
			wr_cnt = same_cnt + CNT_ONE;
			if (same_cnt != CNT_MAX) begin
				wr_en = commit;
			end else begin
				full = 1'b1;
			end
		end else if (found.spare) begin
			wr_en = commit;
		end else if (fill_q < FILL_MAX) begin
			wr_en  = commit;
			wr_idx = fill_q[IDX_W-1:0];
			grow   = 1'b1;
		end else begin
			full = 1'b1;
		end
	end

	assign pairs_nxt = (found.hit && (pairs_q != '1)) ? pairs_q + PAIR_W'(1) : pairs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q         <= '0;
			pairs_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (commit) begin
				if (last_q) begin
					fill_q  <= '0;
					pairs_q <= '0;
				end else begin
					pairs_q <= pairs_nxt;
					if (grow) fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_q.matched    <= found.hit;
			result_q.pair_count <= pairs_nxt;
			result_q.table_full <= full;
			result_q.set_done   <= last_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

### rtl/core/ksp_table.sv
`default_nettype none

module ksp_table #(
	parameter int DEPTH  = 64,
	parameter int IDX_W  = 6,
	parameter int WORD_W = 48
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [IDX_W-1:0]  rd_idx,
	output logic      [WORD_W-1:0] rd_word,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_idx,
	input  wire logic [WORD_W-1:0] wr_word
);

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word <= mem[rd_idx];
		end
	end

endmodule

`default_nettype wire

### rtl/core/ksp_scan.sv
`default_nettype none

module ksp_scan #(
	parameter int IDX_W   = 6,
	parameter int COUNT_W = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic                         ent_vld,
	input  wire logic [IDX_W-1:0]             ent_idx,
	input  wire logic [ksp_pkg::VALUE_W-1:0]  ent_key,
	input  wire logic [COUNT_W-1:0]           ent_cnt,
	input  wire logic [ksp_pkg::VALUE_W-1:0]  value,
	input  wire logic [ksp_pkg::VALUE_W:0]    diff,
	output ksp_pkg::scan_t                    found,
	output logic      [IDX_W-1:0]             hit_idx,
	output logic      [COUNT_W-1:0]           hit_cnt,
	output logic      [IDX_W-1:0]             same_idx,
	output logic      [COUNT_W-1:0]           same_cnt,
	output logic      [IDX_W-1:0]             spare_idx
);

	import ksp_pkg::*;

	scan_t             found_q;
	logic [VALUE_W:0]  key_ext;
	logic              is_hit, is_same, is_spare;

	// diff is one bit wider, so keys are sign extended before the compare
	assign key_ext  = {ent_key[VALUE_W-1], ent_key};
	assign is_hit   = ent_vld && !found_q.hit && (ent_cnt != '0) && (key_ext == diff);
	assign is_same  = ent_vld && !found_q.same && (ent_key == value);
	assign is_spare = ent_vld && !found_q.spare && (ent_cnt == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
		end else if (start) begin
			found_q <= '0;
		end else begin
			if (is_hit)   found_q.hit   <= 1'b1;
			if (is_same)  found_q.same  <= 1'b1;
			if (is_spare) found_q.spare <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (is_hit) begin
			hit_idx <= ent_idx;
			hit_cnt <= ent_cnt;
		end
		if (is_same) begin
			same_idx <= ent_idx;
			same_cnt <= ent_cnt;
		end
		if (is_spare) begin
			spare_idx <= ent_idx;
		end
	end

	assign found = found_q;

endmodule

`default_nettype wire

### rtl/core/ksp_checker.sv
`default_nettype none

module ksp_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_ready,
	input wire logic             result_valid,
	input wire logic             result_ready,
	input wire ksp_pkg::result_t result
);

	import ksp_pkg::*;

	// a held result does not change under backpressure
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// one item at a time: no second transaction right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted during a scan");

	a_match_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.matched && result.table_full))
		else $error("matched and table_full together");

	a_match_counts: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.matched |-> result.pair_count != '0)
		else $error("match reported with zero pair count");

endmodule

bind k_sum_pair_counter_core ksp_checker u_ksp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire
